>>> rtl/swsta_pkg.sv
// shared constants, request codes and divider handshake types
// for the sample window statistics block; no dependencies
package swsta_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int SLOT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int SAMPLE_W    = 32;
	localparam int POS_W       = 15;
	localparam int FRAC_W      = 8;
	localparam int WGT_W       = 9;
	localparam int ACC_W       = 72;
	localparam int DIV_W       = 71;
	localparam int DEN_W       = 15;
	localparam int VAR_W       = 63;

	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_WIN  = 2'd2;
	localparam logic [1:0] REQ_STAT = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOR = 1'b1;

	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/swsta_in_if.sv
// request channel of the sample window statistics block
// valid/ready handshake with the request payload; no dependencies
interface swsta_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [31:0] sample_value;
	logic [5:0]         sample_age;
	logic [14:0]        window_old;
	logic [14:0]        window_new;

	modport source (output valid, req_type, sample_value, sample_age, window_old, window_new,
		input ready);
	modport sink (input valid, req_type, sample_value, sample_age, window_old, window_new,
		output ready);
endinterface

>>> rtl/swsta_out_if.sv
// result channel of the sample window statistics block
// valid/ready handshake with the result payload; no dependencies
interface swsta_out_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [31:0] value;
	logic [62:0]        variance;

	modport source (output valid, status, value, variance, input ready);
	modport sink (input valid, status, value, variance, output ready);
endinterface

>>> rtl/swsta_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on swsta_pkg for widths and the request/response structs
module swsta_div (
	input  logic                clk,
	input  logic                arst_n,
	input  swsta_pkg::div_req_t req,
	output swsta_pkg::div_rsp_t rsp
);
	import swsta_pkg::*;

	localparam logic [6:0] LAST_STEP = 7'(DIV_W - 1);

	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			quo_q <= req.num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/sample_window_statistics.sv
// Sample window statistics: a circular store of up to 64 signed Q16.16 samples.
// Requests arrive on the req channel (valid/ready), one result per request leaves on
// the rsp channel; a transfer happens when valid and ready are both high.
// req_type: add a sample, read by age (0 newest), fraction-weighted window average
// over Q.8 age positions, or mean and population variance of the whole store.
// One request is worked at a time; req.ready is high only while idle.
// The scan goes through the single read port of the sample memory one entry per
// cycle, and every division runs 71 steps of the bit-serial divider.
// A finished result sits in the output register; if the receiver stalls the block
// holds it and waits before loading the next one.
// Reset (arst_n low) sets sample_count to 64, clears the store through per-entry
// valid bits (no clearing pass) and empties the output register.
// The APB port holds sample_count at address 0; a write clears the store the same way.
module sample_window_statistics (
	input  logic        clk,
	input  logic        arst_n,
	swsta_in_if.sink    req,
	swsta_out_if.source rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swsta_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_FIN} state_t;
	typedef enum logic [1:0] {OP_READ, OP_WIN, OP_MEAN, OP_STAT} op_t;
	typedef enum logic [1:0] {SM_SUM, SM_WIN, SM_VAR} scan_t;

	state_t state_q;
	op_t    op_q;
	scan_t  mode_q;

	logic [CNT_W-1:0]        count_q;
	logic [SLOT_W-1:0]       newest_q;
	logic [MAX_SAMPLES-1:0]  valid_q;
	logic [SAMPLE_W-1:0]     mem [MAX_SAMPLES];

	// request decode
	logic                    acc_in;
	logic                    cfg_wr;
	logic [CNT_W-1:0]        cfg_cnt;
	logic [SLOT_W-1:0]       add_slot;
	logic [CNT_W-1:0]        age_sum;
	logic [SLOT_W-1:0]       age_slot;
	logic [CNT_W-1:0]        win_sum;
	logic [SLOT_W-1:0]       win_slot;
	logic [POS_W-1:0]        old_m1;
	logic [CNT_W-1:0]        win_n;
	logic                    win_bad;

	// scan issue
	logic [CNT_W-1:0]        left_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [SLOT_W-1:0]       age_q;
	logic [POS_W-1:0]        pold_q;
	logic [POS_W-1:0]        pnew_q;
	logic [POS_W-1:0]        age_lo;
	logic [POS_W-1:0]        age_hi;
	logic [POS_W-1:0]        w_lo;
	logic [POS_W-1:0]        w_hi;
	logic [POS_W-1:0]        w_diff;
	logic                    issue;
	logic [SLOT_W-1:0]       slot_nx;

	// scan pipeline
	logic [SAMPLE_W-1:0]     rd_data_q;
	logic                    rd_vld_q;
	logic                    pv_a_q, pv1_s1, pv2_s2, pv3_s3;
	logic [WGT_W-1:0]        w_a_q, w_s1, w_s2;
	logic signed [32:0]      val_a;
	logic signed [32:0]      d_s1;
	logic signed [32:0]      m_s2;
	logic signed [ACC_W-1:0] prod_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [42:0]      prod_win;
	logic [63:0]             prod_sq;
	logic                    scan_done;

	// division
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	logic                    div_start_q;
	logic [DIV_W-1:0]        div_num_q;
	logic [DEN_W-1:0]        div_den_q;
	logic                    neg_q;
	logic [DIV_W-1:0]        acc_mag;
	logic [DIV_W-1:0]        quo_s;
	logic [VAR_W-1:0]        var_sat;

	// result
	logic                    res_status_q;
	logic [SAMPLE_W-1:0]     res_value_q;
	logic [VAR_W-1:0]        res_var_q;
	logic                    out_valid_q;
	logic                    out_status_q;
	logic [SAMPLE_W-1:0]     out_value_q;
	logic [VAR_W-1:0]        out_var_q;
	logic                    out_free;
	logic signed [SAMPLE_W-1:0] mean_q;

	assign req.ready = (state_q == ST_IDLE);
	assign acc_in    = req.valid && req.ready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == 1'b0) ? {25'd0, count_q} : 32'd0;
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);

	always_comb begin
		if (pwdata[CNT_W-1:0] == '0)
			cfg_cnt = CNT_W'(1);
		else if (pwdata[CNT_W-1:0] > CNT_W'(MAX_SAMPLES))
			cfg_cnt = CNT_W'(MAX_SAMPLES);
		else
			cfg_cnt = pwdata[CNT_W-1:0];
	end

	assign add_slot = (newest_q == '0) ? SLOT_W'(count_q - CNT_W'(1)) : newest_q - SLOT_W'(1);

	assign age_sum  = {1'b0, newest_q} + {1'b0, req.sample_age};
	assign age_slot = (age_sum >= count_q) ? SLOT_W'(age_sum - count_q) : age_sum[SLOT_W-1:0];

	assign win_sum  = {1'b0, newest_q} + {1'b0, req.window_new[13:8]};
	assign win_slot = (win_sum >= count_q) ? SLOT_W'(win_sum - count_q) : win_sum[SLOT_W-1:0];
	assign old_m1   = req.window_old - POS_W'(1);
	assign win_n    = old_m1[14:8] - {1'b0, req.window_new[13:8]} + CNT_W'(1);
	assign win_bad  = (req.window_old <= req.window_new) ||
		(req.window_old > {count_q, {FRAC_W{1'b0}}});

	// weight of one age: overlap of [age, age+1) with the window, in Q.8
	assign age_lo  = {1'b0, age_q, {FRAC_W{1'b0}}};
	assign age_hi  = {CNT_W'({1'b0, age_q} + CNT_W'(1)), {FRAC_W{1'b0}}};
	assign w_lo    = (pnew_q > age_lo) ? pnew_q : age_lo;
	assign w_hi    = (pold_q < age_hi) ? pold_q : age_hi;
	assign w_diff  = w_hi - w_lo;

	assign issue   = (state_q == ST_SCAN) && (left_q != '0);
	assign slot_nx = (CNT_W'(slot_q) + CNT_W'(1) == count_q) ? '0 : slot_q + SLOT_W'(1);

	assign val_a    = rd_vld_q ? 33'($signed(rd_data_q)) : 33'sd0;
	assign prod_win = m_s2 * $signed({1'b0, w_s2});
	assign prod_sq  = m_s2[31:0] * m_s2[31:0];

	assign scan_done = (left_q == '0) && !pv_a_q && !pv1_s1 && !pv2_s2 && !pv3_s3;

	assign acc_mag = acc_q[ACC_W-1] ? DIV_W'(-acc_q) : DIV_W'(acc_q);
	assign quo_s   = neg_q ? -div_rsp.quo : div_rsp.quo;
	assign var_sat = (div_rsp.quo[DIV_W-1:VAR_W] != '0) ? VAR_MAX : div_rsp.quo[VAR_W-1:0];

	assign out_free = !out_valid_q || rsp.ready;

	assign div_req.start = div_start_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	swsta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sample memory, one read port for scans and one write port for adds
	always_ff @(posedge clk) begin
		if (acc_in && req.req_type == REQ_ADD)
			mem[add_slot] <= req.sample_value;
		rd_data_q <= mem[slot_q];
	end

	// scan pipeline data: read data, difference, magnitude, product
	always_ff @(posedge clk) begin
		rd_vld_q <= valid_q[slot_q];
		w_a_q    <= w_diff[WGT_W-1:0];
		w_s1     <= w_a_q;
		w_s2     <= w_s1;
		d_s1     <= (mode_q == SM_VAR) ? val_a - 33'(mean_q) : val_a;
		m_s2     <= (mode_q == SM_VAR && d_s1[32]) ? -d_s1 : d_s1;
		unique case (mode_q)
			SM_VAR:  prod_s3 <= $signed({8'd0, prod_sq});
			SM_WIN:  prod_s3 <= ACC_W'(prod_win);
			default: prod_s3 <= ACC_W'(m_s2);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_READ;
			mode_q       <= SM_SUM;
			count_q      <= CNT_W'(MAX_SAMPLES);
			newest_q     <= SLOT_W'(MAX_SAMPLES - 1);
			valid_q      <= '0;
			left_q       <= '0;
			pv_a_q       <= 1'b0;
			pv1_s1       <= 1'b0;
			pv2_s2       <= 1'b0;
			pv3_s3       <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_SCAN) && scan_done && (op_q != OP_READ);
			pv_a_q      <= issue;
			pv1_s1      <= pv_a_q;
			pv2_s2      <= pv1_s1;
			pv3_s3      <= pv2_s2;
			if (issue) begin
				left_q <= left_q - CNT_W'(1);
				slot_q <= slot_nx;
				age_q  <= age_q + SLOT_W'(1);
			end
			if (pv3_s3)
				acc_q <= acc_q + prod_s3;
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;

			if (cfg_wr) begin
				count_q  <= cfg_cnt;
				newest_q <= SLOT_W'(cfg_cnt - CNT_W'(1));
				valid_q  <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						res_status_q <= STATUS_OK;
						res_value_q  <= '0;
						res_var_q    <= '0;
						acc_q        <= '0;
						mode_q       <= SM_SUM;
						pold_q       <= req.window_old;
						pnew_q       <= req.window_new;
						slot_q       <= newest_q;
						age_q        <= '0;
						left_q       <= count_q;
						unique case (req.req_type)
							REQ_ADD: begin
								newest_q          <= add_slot;
								valid_q[add_slot] <= 1'b1;
								state_q           <= ST_FIN;
							end
							REQ_READ: begin
								op_q <= OP_READ;
								if (req.sample_age >= count_q) begin
									res_status_q <= STATUS_OOR;
									state_q      <= ST_FIN;
								end else begin
									slot_q  <= age_slot;
									left_q  <= CNT_W'(1);
									state_q <= ST_SCAN;
								end
							end
							REQ_WIN: begin
								if (req.window_old == '0 && req.window_new == '0) begin
									op_q    <= OP_MEAN;
									state_q <= ST_SCAN;
								end else if (win_bad) begin
									op_q         <= OP_WIN;
									res_status_q <= STATUS_OOR;
									state_q      <= ST_FIN;
								end else begin
									op_q    <= OP_WIN;
									mode_q  <= SM_WIN;
									slot_q  <= win_slot;
									age_q   <= req.window_new[13:8];
									left_q  <= win_n;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								op_q    <= OP_STAT;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						if (op_q == OP_READ) begin
							res_value_q <= acc_q[SAMPLE_W-1:0];
							state_q     <= ST_FIN;
						end else begin
							div_num_q   <= acc_mag;
							neg_q       <= acc_q[ACC_W-1];
							div_den_q   <= (op_q == OP_WIN) ? pold_q - pnew_q : DEN_W'(count_q);
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (mode_q == SM_VAR) begin
							res_value_q <= mean_q;
							res_var_q   <= var_sat;
							state_q     <= ST_FIN;
						end else if (op_q == OP_STAT) begin
							// second pass: squared deviations from the mean
							mean_q  <= $signed(quo_s[SAMPLE_W-1:0]);
							mode_q  <= SM_VAR;
							acc_q   <= '0;
							slot_q  <= newest_q;
							left_q  <= count_q;
							state_q <= ST_SCAN;
						end else begin
							res_value_q <= quo_s[SAMPLE_W-1:0];
							state_q     <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_value_q  <= res_value_q;
						out_var_q    <= res_var_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.value    = out_value_q;
	assign rsp.variance = out_var_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_SAMPLES)))
		else $error("sample count out of range");

	a_newest_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(newest_q) < count_q)
		else $error("newest slot outside the store in use");

	a_scan_no_reissue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && left_q == '0) |=> (left_q == '0))
		else $error("scan issued reads after it drained");

	a_no_div_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !scan_done) |-> !div_start_q)
		else $error("divider started while the scan was still running");

endmodule

>>> tb/swsta_checker.sv
`timescale 1ns / 100ps
// result checker for sample_window_statistics: predicts each accepted request
// and compares the result transfers; depends on swsta_pkg and the channel interfaces
module swsta_checker
	import swsta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	swsta_in_if         req,
	swsta_out_if        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic             status;
		logic [31:0]      value;
		logic [VAR_W-1:0] variance;
	} stats_result_t;

	logic signed [31:0] samples[MAX_SAMPLES];
	int                 newest;
	int                 count;
	stats_result_t      awaited[$];

	assign pending = awaited.size();

	function automatic void clear_samples(int n);
		foreach (samples[i]) samples[i] = '0;
		count  = n;
		newest = n - 1;
	endfunction

	function automatic longint sample_at(int age);
		int slot;
		slot = newest + age;
		if (slot >= count) slot -= count;
		return longint'(samples[slot]);
	endfunction

	function automatic longint store_mean();
		longint sum;
		sum = 0;
		for (int i = 0; i < count; i++) sum += longint'(samples[i]);
		return sum / count;
	endfunction

	function automatic stats_result_t predict_request(logic [1:0] kind, logic [31:0] smp,
		logic [5:0] age, logic [14:0] w_old, logic [14:0] w_new);
		stats_result_t res;
		longint        p_old, p_new, acc, idx, mean, d;
		logic [63:0]   mag;
		logic [127:0]  sq_sum, quo;
		res = '{STATUS_OK, '0, '0};
		case (kind)
			REQ_ADD: begin
				newest = (newest == 0) ? count - 1 : newest - 1;
				samples[newest] = smp;
			end
			REQ_READ: begin
				if (age >= count) res.status = STATUS_OOR;
				else res.value = 32'(sample_at(int'(age)));
			end
			REQ_WIN: begin
				p_old = longint'(w_old);
				p_new = longint'(w_new);
				if (p_old == 0 && p_new == 0) res.value = 32'(store_mean());
				else if (p_old <= p_new || p_old > count * 256) res.status = STATUS_OOR;
				else begin
					idx = p_new / 256;
					// both edges inside one sample
					if (p_old <= (idx + 1) * 256) res.value = 32'(sample_at(int'(idx)));
					else begin
						acc = ((idx + 1) * 256 - p_new) * sample_at(int'(idx));
						idx++;
						while (p_old > (idx + 1) * 256) begin
							acc += 256 * sample_at(int'(idx));
							idx++;
						end
						acc += (p_old - idx * 256) * sample_at(int'(idx));
						res.value = 32'(acc / (p_old - p_new));
					end
				end
			end
			default: begin
				mean = store_mean();
				sq_sum = '0;
				for (int i = 0; i < count; i++) begin
					d = longint'(samples[i]) - mean;
					mag = (d < 0) ? -d : d;
					sq_sum += {64'd0, mag} * {64'd0, mag};
				end
				quo = sq_sum / count;
				res.value = 32'(mean);
				res.variance = (quo >= (128'd1 << 63)) ? VAR_MAX : quo[62:0];
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_result_t exp_r;
		stats_result_t pred_r;
		int            c;
		if (!arst_n) begin
			clear_samples(MAX_SAMPLES);
			awaited.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
				c = int'(pwdata[6:0]);
				if (c == 0) c = 1;
				else if (c > MAX_SAMPLES) c = MAX_SAMPLES;
				clear_samples(c);
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transfer at %0t", $time);
				end else begin
					exp_r = awaited.pop_front();
					if (rsp.status !== exp_r.status || rsp.value !== exp_r.value ||
						rsp.variance !== exp_r.variance) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at %0t: expected st=%0d val=%h var=%h",
								$time, exp_r.status, exp_r.value, exp_r.variance);
							$display("  got st=%0d val=%h var=%h",
								rsp.status, rsp.value, rsp.variance);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				pred_r = predict_request(req.req_type, req.sample_value,
					req.sample_age, req.window_old, req.window_new);
				awaited = {awaited, pred_r};
			end
		end
	end

endmodule

>>> tb/tb_sample_window_statistics.sv
`timescale 1ns / 100ps
// stimulus and verdict for sample_window_statistics; depends on swsta_pkg,
// the channel interfaces, the block itself and swsta_checker
module tb_sample_window_statistics;
	import swsta_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          errors, pending;
	int          cycles;
	int          cur_count;
	bit          quiet;

	swsta_in_if  req_if ();
	swsta_out_if rsp_if ();

	sample_window_statistics dut (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	swsta_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_if.ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
		end
	end

	task automatic send(logic [1:0] kind, logic [31:0] smp, logic [5:0] age,
		logic [14:0] w_old, logic [14:0] w_new);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_if.valid        = 1'b1;
		req_if.req_type     = kind;
		req_if.sample_value = smp;
		req_if.sample_age   = age;
		req_if.window_old   = w_old;
		req_if.window_new   = w_new;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		req_if.valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (addr == 3'd0)
			cur_count = (data[6:0] == 0) ? 1 : (data[6:0] > MAX_SAMPLES) ? MAX_SAMPLES : data[6:0];
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		int          lim, k;
		logic [14:0] w_old, w_new;
		lim = cur_count * 256;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7:
				send(REQ_ADD, pick_sample(), 6'($urandom), 15'($urandom), 15'($urandom));
			8, 9, 10, 11: begin
				k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
					$urandom_range(0, cur_count - 1);
				send(REQ_READ, $urandom, 6'(k), 15'($urandom), 15'($urandom));
			end
			12, 13, 14, 15: begin
				w_old = 15'($urandom_range(1, lim));
				w_new = 15'($urandom_range(0, w_old - 1));
				send(REQ_WIN, $urandom, 6'($urandom), w_old, w_new);
			end
			16: begin
				// edges inside one sample
				k = $urandom_range(0, cur_count - 1);
				w_new = 15'(k * 256 + $urandom_range(0, 254));
				w_old = 15'($urandom_range(w_new + 1, k * 256 + 256));
				send(REQ_WIN, $urandom, 6'($urandom), w_old, w_new);
			end
			17: send(REQ_WIN, $urandom, 6'($urandom), 15'($urandom), 15'($urandom));
			default: send(REQ_STAT, $urandom, 6'($urandom), 15'($urandom), 15'($urandom));
		endcase
	endtask

	initial begin
		int counts[8] = '{0, 127, 64, 1, 7, 33, 65, 2};
		cycles  = 0;
		quiet   = 1'b0;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cur_count = MAX_SAMPLES;
		req_if.valid        = 1'b0;
		req_if.req_type     = REQ_ADD;
		req_if.sample_value = '0;
		req_if.sample_age   = '0;
		req_if.window_old   = '0;
		req_if.window_new   = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part on the reset setting
		send(REQ_STAT, 0, 0, 0, 0);
		send(REQ_READ, 0, 63, 0, 0);
		send(REQ_ADD, 32'h7fff_ffff, 0, 0, 0);
		send(REQ_ADD, 32'h8000_0000, 0, 0, 0);
		send(REQ_ADD, 32'hffff_ffff, 0, 0, 0);
		send(REQ_ADD, 32'h0001_8000, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0);
		send(REQ_READ, 0, 3, 0, 0);
		send(REQ_WIN, 0, 0, 0, 0);
		send(REQ_WIN, 0, 0, 15'd16384, 0);
		send(REQ_WIN, 0, 0, 15'd16385, 0);
		send(REQ_WIN, 0, 0, 15'h7fff, 15'h7fff);
		send(REQ_WIN, 0, 0, 15'd256, 15'd256);
		send(REQ_WIN, 0, 0, 15'd100, 15'd300);
		send(REQ_WIN, 0, 0, 15'd512, 15'd300);
		send(REQ_WIN, 0, 0, 15'd300, 15'd0);
		send(REQ_WIN, 0, 0, 15'd1000, 15'd130);
		send(REQ_STAT, 0, 0, 0, 0);
		for (int i = 0; i < 64; i++) send(REQ_ADD, (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff, 0, 0, 0);
		send(REQ_STAT, 0, 0, 0, 0);
		send(REQ_WIN, 0, 0, 15'd16384, 15'd1);
		repeat (180) random_request();

		write_reg(3'd4, 32'd5);
		foreach (counts[p]) begin
			write_reg(3'd0, counts[p]);
			if (p == 7) quiet = 1'b1;
			repeat (180) random_request();
		end
		req_if.valid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
